@@ rtl/sxcc_pkg.sv @@
// ----------------------------------------------------------------------------
// sxcc_pkg
// Shared constants, types and elaboration-time table builders for the
// sRGB <-> XYZ color converter.
// ----------------------------------------------------------------------------
package sxcc_pkg;

  localparam int CoefFracBitsDef   = 14;
  localparam int LinearFracBitsDef = 16;
  localparam int XyzFracBitsDef    = 15;

  localparam int ChanW    = 16;
  localparam int CodeW    = 8;
  localparam int TabDepth = 256;
  localparam int TabMaxW  = 25;

  localparam int  WorkBits = 30;
  localparam longint unsigned WorkOne  = 64'd1 << WorkBits;
  localparam longint unsigned WorkHalf = 64'd1 << (WorkBits - 1);

  localparam longint unsigned Million   = 64'd1000000;
  localparam longint unsigned MilHalf   = 64'd500000;
  localparam longint unsigned KneeLimit = 64'd4045 * 64'd510;
  localparam longint unsigned LinDen    = 64'd1292 * 64'd510;
  localparam longint unsigned LinHalf   = 64'd1292 * 64'd255;
  localparam longint unsigned PowDen    = 64'd1055 * 64'd510;
  localparam longint unsigned PowHalf   = 64'd1055 * 64'd255;

  typedef logic [TabMaxW-1:0] tab_t [TabDepth];
  typedef longint coef_arr_t [9];

  localparam coef_arr_t FwdMicro = '{
    412391, 357584, 180481,
    212639, 715169, 72192,
    19331, 119195, 950532
  };
  localparam coef_arr_t InvMicro = '{
    3240970, -1537383, -498611,
    -969244, 1875968, 41555,
    55630, -203977, 1056972
  };

  function automatic longint unsigned wmul(longint unsigned a, longint unsigned b);
    return (a * b + WorkHalf) >> WorkBits;
  endfunction

  function automatic longint unsigned pow5(longint unsigned z);
    longint unsigned p;
    p = wmul(z, z);
    p = wmul(p, z);
    p = wmul(p, z);
    return wmul(p, z);
  endfunction

  // num is the numerator over 510
  function automatic longint unsigned to_linear(longint unsigned num, int lfb);
    longint unsigned y;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    if (num * 64'd100000 <= KneeLimit) begin
      y = (((num * 64'd100) << WorkBits) + LinHalf) / LinDen;
    end else begin
      t = (((64'd1000 * num + 64'd55 * 64'd510) << WorkBits) + PowHalf) / PowDen;
      if (t > WorkOne) t = WorkOne;
      t2 = wmul(t, t);
      lo = 0;
      hi = WorkOne;
      while (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (pow5(mid) <= t2) lo = mid;
        else hi = mid - 64'd1;
      end
      y = wmul(t2, lo);
    end
    if (y > WorkOne) y = WorkOne;
    return (y + (64'd1 << (WorkBits - lfb - 1))) >> (WorkBits - lfb);
  endfunction

  function automatic tab_t build_rom(int lfb);
    tab_t r;
    for (int i = 0; i < TabDepth; i++) r[i] = TabMaxW'(to_linear(64'(2 * i), lfb));
    return r;
  endfunction

  // entry 0 is zero, entry k is the decision threshold between codes k-1 and k
  function automatic tab_t build_thresh(int lfb);
    tab_t r;
    r[0] = '0;
    for (int k = 1; k < TabDepth; k++) r[k] = TabMaxW'(to_linear(64'(2 * k - 1), lfb));
    return r;
  endfunction

  function automatic coef_arr_t quant_all(bit inv, int cfb);
    coef_arr_t r;
    longint m;
    longint unsigned mag;
    longint unsigned q;
    for (int i = 0; i < 9; i++) begin
      m = inv ? InvMicro[i] : FwdMicro[i];
      mag = (m < 0) ? longint'(-m) : longint'(m);
      q = ((mag << cfb) + MilHalf) / Million;
      r[i] = (m < 0) ? -longint'(q) : longint'(q);
    end
    return r;
  endfunction

endpackage

@@ rtl/sxcc_if.sv @@
// ----------------------------------------------------------------------------
// sxcc_in_if / sxcc_out_if / sxcc_cfg_if
// Valid/ready channels for pixels in, pixels out and the direction register.
// ----------------------------------------------------------------------------
interface sxcc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] channel_a;
  logic [15:0] channel_b;
  logic [15:0] channel_c;
  modport source (output valid, channel_a, channel_b, channel_c, input ready);
  modport sink   (input valid, channel_a, channel_b, channel_c, output ready);
endinterface

interface sxcc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_a;
  logic [15:0] out_b;
  logic [15:0] out_c;
  modport source (output valid, out_a, out_b, out_c, input ready);
  modport sink   (input valid, out_a, out_b, out_c, output ready);
endinterface

interface sxcc_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/srgb_xyz_color_converter.sv @@
// Throughput: one word per cycle while out_px.ready holds; the two-entry
// queue and a four-stage back pipeline with per-stage enables let each side
// stall on its own.
// Reset clears the direction register (sRGB to XYZ) and all valid flags;
// the linearization ROM and threshold table are constants.
// ----------------------------------------------------------------------------
// srgb_xyz_color_converter
// Per-pixel sRGB <-> CIE XYZ (D65) converter, top level.
// ----------------------------------------------------------------------------
module srgb_xyz_color_converter #(
  parameter int COEF_FRAC_BITS   = sxcc_pkg::CoefFracBitsDef,
  parameter int LINEAR_FRAC_BITS = sxcc_pkg::LinearFracBitsDef,
  parameter int XYZ_FRAC_BITS    = sxcc_pkg::XyzFracBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  sxcc_in_if.sink     in_px,
  sxcc_cfg_if.sink    cfg_wr,
  sxcc_out_if.source  out_px
);
  import sxcc_pkg::*;

  localparam int LW    = LINEAR_FRAC_BITS + 1;
  localparam int OPW   = (LW > ChanW) ? LW : ChanW;
  localparam int ENT_W = 3 * OPW + 1;

  logic f_valid, f_ready, b_valid, b_ready;
  logic [ENT_W-1:0] f_data, b_data;

  sxcc_front #(
    .LINEAR_FRAC_BITS(LINEAR_FRAC_BITS),
    .ENT_W(ENT_W)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .in_px(in_px), .cfg_wr(cfg_wr),
    .q_ready(f_ready), .q_valid(f_valid), .q_data(f_data)
  );

  sxcc_queue #(.ENT_W(ENT_W)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  sxcc_back #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .LINEAR_FRAC_BITS(LINEAR_FRAC_BITS),
    .XYZ_FRAC_BITS(XYZ_FRAC_BITS),
    .ENT_W(ENT_W)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
    .out_px(out_px)
  );
endmodule

@@ rtl/sxcc_front.sv @@
// ----------------------------------------------------------------------------
// sxcc_front
// Accept words, hold the direction, look up linear values for sRGB codes.
// ----------------------------------------------------------------------------
module sxcc_front #(
  parameter int LINEAR_FRAC_BITS = 16,
  parameter int ENT_W            = 52
) (
  input  logic             clk,
  input  logic             rst_n,
  sxcc_in_if.sink          in_px,
  sxcc_cfg_if.sink         cfg_wr,
  input  logic             q_ready,
  output logic             q_valid,
  output logic [ENT_W-1:0] q_data
);
  import sxcc_pkg::*;

  localparam int LW  = LINEAR_FRAC_BITS + 1;
  localparam int OPW = (LW > ChanW) ? LW : ChanW;
  localparam tab_t LinRom = build_rom(LINEAR_FRAC_BITS);

  logic dir_r, dir_nxt;
  logic [OPW-1:0] op [3];
  logic [ChanW-1:0] ch [3];

  assign cfg_wr.ready = 1'b1;
  assign dir_nxt      = (cfg_wr.valid) ? cfg_wr.data : dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) dir_r <= 1'b0;
    else dir_r <= dir_nxt;
  end

  assign ch[0] = in_px.channel_a;
  assign ch[1] = in_px.channel_b;
  assign ch[2] = in_px.channel_c;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (dir_r) op[j] = OPW'(ch[j]);
      else op[j] = OPW'(LinRom[ch[j][CodeW-1:0]][LW-1:0]);
    end
  end

  assign in_px.ready = q_ready;
  assign q_valid     = in_px.valid;
  assign q_data      = {dir_r, op[2], op[1], op[0]};
endmodule

@@ rtl/sxcc_queue.sv @@
// ----------------------------------------------------------------------------
// sxcc_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module sxcc_queue #(
  parameter int ENT_W = 52
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [ENT_W-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [ENT_W-1:0] rd_data
);
  logic [ENT_W-1:0] mem_r [2];
  logic wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end
endmodule

@@ rtl/sxcc_back.sv @@
// ----------------------------------------------------------------------------
// sxcc_back
// Matrix multiply, rescale or clamp, gamma-encode by threshold search.
// ----------------------------------------------------------------------------
module sxcc_back #(
  parameter int COEF_FRAC_BITS   = 14,
  parameter int LINEAR_FRAC_BITS = 16,
  parameter int XYZ_FRAC_BITS    = 15,
  parameter int ENT_W            = 52
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  logic [ENT_W-1:0] q_data,
  sxcc_out_if.source       out_px
);
  import sxcc_pkg::*;

  localparam int LW    = LINEAR_FRAC_BITS + 1;
  localparam int OPW   = (LW > ChanW) ? LW : ChanW;
  localparam int CW    = COEF_FRAC_BITS + 3;
  localparam int PW    = CW + OPW + 1;
  localparam int AW0   = PW + 2;
  localparam int AW1   = COEF_FRAC_BITS + XYZ_FRAC_BITS + 2;
  localparam int ACC_W = (AW0 > AW1) ? AW0 : AW1;
  localparam int EXT_W = ACC_W + 4;
  localparam int SHF   = COEF_FRAC_BITS + LINEAR_FRAC_BITS - XYZ_FRAC_BITS;
  localparam int SHF_R = (SHF > 0) ? SHF : 1;
  localparam int SHF_L = (SHF < 0) ? -SHF : 0;
  localparam int SHV   = COEF_FRAC_BITS + XYZ_FRAC_BITS - LINEAR_FRAC_BITS;
  localparam int SHV_R = (SHV > 0) ? SHV : 1;
  localparam int SHV_L = (SHV < 0) ? -SHV : 0;

  localparam coef_arr_t FwdQ = quant_all(1'b0, COEF_FRAC_BITS);
  localparam coef_arr_t InvQ = quant_all(1'b1, COEF_FRAC_BITS);
  localparam tab_t Thr = build_thresh(LINEAR_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] OneRev =
    ACC_W'(1) << (COEF_FRAC_BITS + XYZ_FRAC_BITS);

  logic en1, en2, en3, en4;
  logic [OPW-1:0] op [3];
  logic q_dir;

  logic v1_r, d1_r;
  logic signed [PW-1:0] p1_r [9];
  logic v2_r, d2_r;
  logic [ChanW-1:0] f2_r [3];
  logic [LW-1:0] l2_r [3];
  logic v3_r, d3_r;
  logic [ChanW-1:0] f3_r [3];
  logic [LW-1:0] l3_r [3];
  logic [CodeW-1:0] c3_r [3];
  logic v4_r;
  logic [ChanW-1:0] o4_r [3];

  logic signed [PW-1:0] p1_nxt [9];
  logic [ChanW-1:0] f2_nxt [3];
  logic [LW-1:0] l2_nxt [3];
  logic [CodeW-1:0] c3_nxt [3];
  logic [ChanW-1:0] o4_nxt [3];

  assign en4     = !v4_r || out_px.ready;
  assign en3     = !v3_r || en4;
  assign en2     = !v2_r || en3;
  assign en1     = !v1_r || en2;
  assign q_ready = en1;

  assign q_dir = q_data[ENT_W-1];
  always_comb begin
    for (int j = 0; j < 3; j++) op[j] = q_data[j*OPW +: OPW];
  end

  always_comb begin
    logic signed [CW-1:0] cf;
    for (int i = 0; i < 9; i++) begin
      cf = q_dir ? InvQ[i][CW-1:0] : FwdQ[i][CW-1:0];
      p1_nxt[i] = PW'(cf * $signed({1'b0, op[i%3]}));
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] v;
    for (int r = 0; r < 3; r++) begin
      acc = ACC_W'(p1_r[3*r]) + ACC_W'(p1_r[3*r+1]) + ACC_W'(p1_r[3*r+2]);
      ext = EXT_W'($unsigned(acc));
      if (SHF > 0) v = (ext + (EXT_W'(1) << (SHF_R - 1))) >> SHF_R;
      else v = ext << SHF_L;
      f2_nxt[r] = (v > EXT_W'(16'hFFFF)) ? 16'hFFFF : v[ChanW-1:0];
      if (acc < 0) acc = '0;
      if (acc > OneRev) acc = OneRev;
      ext = EXT_W'($unsigned(acc));
      if (SHV > 0) v = (ext + (EXT_W'(1) << (SHV_R - 1))) >> SHV_R;
      else v = ext << SHV_L;
      l2_nxt[r] = v[LW-1:0];
    end
  end

  always_comb begin
    logic [CodeW-1:0] c;
    logic [CodeW-1:0] cand;
    for (int r = 0; r < 3; r++) begin
      c = '0;
      for (int b = CodeW - 1; b >= CodeW / 2; b--) begin
        cand = c | (CodeW'(1) << b);
        if (Thr[cand][LW-1:0] <= l2_r[r]) c = cand;
      end
      c3_nxt[r] = c;
    end
  end

  always_comb begin
    logic [CodeW-1:0] c;
    logic [CodeW-1:0] cand;
    for (int r = 0; r < 3; r++) begin
      c = c3_r[r];
      for (int b = CodeW / 2 - 1; b >= 0; b--) begin
        cand = c | (CodeW'(1) << b);
        if (Thr[cand][LW-1:0] <= l3_r[r]) c = cand;
      end
      o4_nxt[r] = d3_r ? ChanW'(c) : f3_r[r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= q_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d1_r <= q_dir;
      p1_r <= p1_nxt;
    end
    if (en2) begin
      d2_r <= d1_r;
      f2_r <= f2_nxt;
      l2_r <= l2_nxt;
    end
    if (en3) begin
      d3_r <= d2_r;
      f3_r <= f2_r;
      l3_r <= l2_r;
      c3_r <= c3_nxt;
    end
    if (en4) o4_r <= o4_nxt;
  end

  assign out_px.valid = v4_r;
  assign out_px.out_a = o4_r[0];
  assign out_px.out_b = o4_r[1];
  assign out_px.out_c = o4_r[2];
endmodule

@@ dv/srgb_xyz_color_converter_chk.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srgb_xyz_color_converter_chk
// Watches the pixel and direction channels, predicts each result word from
// its own tables and matrices, and compares the words in order.
// ----------------------------------------------------------------------------
module srgb_xyz_color_converter_chk (
  input  logic       clk,
  input  logic       rst_n,
  sxcc_in_if.sink    px_in,
  sxcc_cfg_if.sink   dir_wr,
  sxcc_out_if.sink   px_out,
  output int         fail_cnt,
  output int         pending_cnt
);

  localparam int CFB = 14;
  localparam int LFB = 16;
  localparam int XFB = 15;
  localparam longint unsigned UNIT = 64'd1 << 30;

  typedef struct {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
  } pixel_t;

  longint unsigned lin_lut [256];
  longint unsigned code_edge [255];
  longint m_fwd [9];
  longint m_inv [9];
  bit dir_q;
  pixel_t pixels_due [$];

  function automatic longint unsigned fx_mul(longint unsigned x, longint unsigned y);
    return (x * y + (UNIT >> 1)) >> 30;
  endfunction

  function automatic longint unsigned fifth(longint unsigned z);
    longint unsigned p;
    p = fx_mul(z, z);
    p = fx_mul(p, z);
    p = fx_mul(p, z);
    return fx_mul(p, z);
  endfunction

  function automatic longint unsigned decode_gamma(longint unsigned n, longint unsigned d);
    longint unsigned y, t, t2, lo, hi, mid, q;
    if (n * 100000 <= 4045 * d) begin
      q = 1292 * d;
      y = (((n * 100) << 30) + q / 2) / q;
    end else begin
      q = 1055 * d;
      t = (((1000 * n + 55 * d) << 30) + q / 2) / q;
      if (t > UNIT) t = UNIT;
      t2 = fx_mul(t, t);
      lo = 0;
      hi = UNIT;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (fifth(mid) <= t2) lo = mid;
        else hi = mid - 1;
      end
      y = fx_mul(t2, lo);
    end
    if (y > UNIT) y = UNIT;
    return (y + (64'd1 << (30 - LFB - 1))) >> (30 - LFB);
  endfunction

  function automatic longint coef_q(longint micro);
    longint unsigned mag, q;
    mag = micro < 0 ? -micro : micro;
    q = ((mag << CFB) + 500000) / 1000000;
    return micro < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] gamma_code(longint acc);
    longint one;
    longint unsigned lv;
    int n;
    one = 64'sd1 << (CFB + XFB);
    n = 0;
    if (acc < 0) acc = 0;
    if (acc > one) acc = one;
    lv = (longint'(acc) + (64'sd1 << (CFB + XFB - LFB - 1))) >> (CFB + XFB - LFB);
    for (int k = 0; k < 255; k++) if (lv >= code_edge[k]) n++;
    return 16'(n);
  endfunction

  function automatic pixel_t convert_pixel(pixel_t p, bit rev);
    pixel_t r;
    logic [15:0] v [3];
    logic [15:0] o [3];
    longint acc;
    longint unsigned u;
    v[0] = p.a; v[1] = p.b; v[2] = p.c;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      if (!rev) begin
        for (int j = 0; j < 3; j++) acc += m_fwd[i*3+j] * longint'(lin_lut[v[j][7:0]]);
        u = (longint'(acc) + (64'sd1 << (CFB + LFB - XFB - 1))) >> (CFB + LFB - XFB);
        o[i] = u > 65535 ? 16'hFFFF : 16'(u);
      end else begin
        for (int j = 0; j < 3; j++) acc += m_inv[i*3+j] * longint'({48'd0, v[j]});
        o[i] = gamma_code(acc);
      end
    end
    r.a = o[0]; r.b = o[1]; r.c = o[2];
    return r;
  endfunction

  initial begin
    longint fm [9];
    longint im [9];
    fm = '{412391, 357584, 180481, 212639, 715169, 72192,
           19331, 119195, 950532};
    im = '{3240970, -1537383, -498611, -969244, 1875968, 41555,
           55630, -203977, 1056972};
    for (int i = 0; i < 256; i++) lin_lut[i] = decode_gamma(i, 255);
    for (int i = 0; i < 255; i++) code_edge[i] = decode_gamma(2 * i + 1, 510);
    for (int i = 0; i < 9; i++) begin
      m_fwd[i] = coef_q(fm[i]);
      m_inv[i] = coef_q(im[i]);
    end
  end

  initial fail_cnt = 0;
  initial pending_cnt = 0;

  always @(posedge clk) begin
    pixel_t got, want, in_w;
    if (!rst_n) begin
      dir_q <= 1'b0;
      pixels_due.delete();
    end else begin
      if (dir_wr.valid && dir_wr.ready) dir_q <= dir_wr.data;
      if (px_in.valid && px_in.ready) begin
        in_w.a = px_in.channel_a; in_w.b = px_in.channel_b; in_w.c = px_in.channel_c;
        pixels_due.push_back(convert_pixel(in_w, dir_q));
      end
      if (px_out.valid && px_out.ready) begin
        got.a = px_out.out_a; got.b = px_out.out_b; got.c = px_out.out_c;
        if (pixels_due.size() == 0) begin
          $error("unexpected word a=%h b=%h c=%h", got.a, got.b, got.c);
          fail_cnt++;
        end else begin
          want = pixels_due.pop_front();
          if (got.a !== want.a) begin
            $error("out_a expected %h actual %h", want.a, got.a); fail_cnt++;
          end
          if (got.b !== want.b) begin
            $error("out_b expected %h actual %h", want.b, got.b); fail_cnt++;
          end
          if (got.c !== want.c) begin
            $error("out_c expected %h actual %h", want.c, got.c); fail_cnt++;
          end
        end
      end
    end
    pending_cnt = pixels_due.size();
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives pixels in both directions with random gaps and back-pressure,
// including a long output stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;

  logic clk;
  logic rst_n;
  int   fail_cnt;
  int   pending_cnt;
  int   cycle_cnt;
  bit   calm;
  bit   hold_out;

  sxcc_in_if  px_in ();
  sxcc_out_if px_out ();
  sxcc_cfg_if dir_wr ();

  srgb_xyz_color_converter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (px_in.sink),
    .cfg_wr (dir_wr.sink),
    .out_px (px_out.source)
  );

  srgb_xyz_color_converter_chk chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .px_in       (px_in.sink),
    .dir_wr      (dir_wr.sink),
    .px_out      (px_out.sink),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > 200000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold
  initial begin
    int n;
    px_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        px_out.ready <= 1'b0;
        repeat (60) @(negedge clk);
        hold_out = 1'b0;
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        px_out.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        px_out.ready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 12);
      px_in.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    px_in.valid     <= 1'b1;
    px_in.channel_a <= a;
    px_in.channel_b <= b;
    px_in.channel_c <= c;
    do @(posedge clk); while (!px_in.ready);
    @(negedge clk);
  endtask

  task automatic set_direction(bit d);
    px_in.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    dir_wr.valid <= 1'b1;
    dir_wr.data  <= d;
    do @(posedge clk); while (!dir_wr.ready);
    @(negedge clk);
    dir_wr.valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_word(bit rev);
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return rev ? 16'($urandom_range(0, 32768)) : 16'($urandom_range(0, 255));
      3: return rev ? 16'($urandom_range(32760, 32776)) : 16'($urandom_range(0, 12));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    bit d;
    calm = 1'b0;
    hold_out = 1'b0;
    rst_n = 1'b0;
    px_in.valid = 1'b0;
    px_in.channel_a = '0;
    px_in.channel_b = '0;
    px_in.channel_c = '0;
    dir_wr.valid = 1'b0;
    dir_wr.data = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    send_pixel(16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'h00FF, 16'h00FF, 16'h00FF);
    send_pixel(16'hFF00, 16'hAB0A, 16'h5580);
    send_pixel(16'h0001, 16'h000A, 16'h000B);
    send_pixel(16'h00FF, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'h00FF);
    hold_out = 1'b1;
    for (int i = 0; i < 80; i++) send_pixel(16'($urandom), 16'($urandom), 16'($urandom));

    set_direction(1'b1);
    send_pixel(16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h7A1D, 16'h8000, 16'h8B4C);
    send_pixel(16'h8000, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'h8000, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'h8000);
    send_pixel(16'h0010, 16'h0010, 16'h0010);
    send_pixel(16'h3000, 16'h4000, 16'h2000);

    for (int ph = 0; ph < 6; ph++) begin
      d = ph[0];
      set_direction(d);
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < 250; i++) send_pixel(rand_word(d), rand_word(d), rand_word(d));
    end

    px_in.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ srgb_xyz_color_converter.f @@
rtl/sxcc_pkg.sv
rtl/sxcc_if.sv
rtl/sxcc_front.sv
rtl/sxcc_queue.sv
rtl/sxcc_back.sv
rtl/srgb_xyz_color_converter.sv
dv/srgb_xyz_color_converter_chk.sv
dv/tb.sv
